>>> rtl/spwn_pkg.sv
`default_nettype none

package spwn_pkg;

	// Field widths of the sample and result formats.
	localparam int SAMPLE_W   = 16;
	localparam int PEAK_W     = 15;
	localparam int NORM_W     = 20;
	localparam int FRAC_SHIFT = 12;
	localparam int DIVIDEND_W = SAMPLE_W + FRAC_SHIFT;

	// Window depth default and the serial divider's step count.
	localparam int WINDOW_DEF = 256;
	localparam int DIV_STEPS  = DIVIDEND_W;
	localparam int DCNT_W     = $clog2(DIV_STEPS);

	// Register reset value and saturation limits.
	localparam logic [PEAK_W-1:0]          FLOOR_RESET = 15'd3277;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN  = 16'sh8000;
	localparam logic [DIVIDEND_W-1:0]      POS_LIM     = 28'd524287;
	localparam logic [DIVIDEND_W-1:0]      NEG_LIM     = 28'd524288;
	localparam logic signed [NORM_W-1:0]   NORM_MAX    = 20'sh7FFFF;
	localparam logic signed [NORM_W-1:0]   NORM_MIN    = 20'sh80000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] left_norm;
		logic signed [NORM_W-1:0] right_norm;
		logic signed [NORM_W-1:0] mono_norm;
		logic [PEAK_W-1:0]        left_peak;
		logic [PEAK_W-1:0]        right_peak;
	} out_item_t;

	// Sequencer controls shared by both lanes.
	typedef struct packed {
		logic load;
		logic scan_rd;
		logic acc;
		logic acc_ok;
		logic div_start;
		logic div_step;
	} lane_ctrl_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] norm;
		logic [PEAK_W-1:0]        peak;
	} lane_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIVLD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> rtl/spwn_div.sv
`default_nettype none

module spwn_div import spwn_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  start,
	input  wire logic                  step,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [PEAK_W-1:0]     divisor,
	output logic [DIVIDEND_W-1:0]      quotient
);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [PEAK_W-1:0]     rem_q;
	logic [PEAK_W-1:0]     div_q;
	logic [PEAK_W:0]       shifted;
	logic [PEAK_W:0]       trial;
	logic                  fits;

	// One restoring step: shift in the next dividend bit and try the subtract.
	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		fits    = shifted >= {1'b0, div_q};
		trial   = shifted - {1'b0, div_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (step) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? trial[PEAK_W-1:0] : shifted[PEAK_W-1:0];
		end
	end

	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/spwn_lane.sv
`default_nettype none

module spwn_lane import spwn_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	localparam int AW    = $clog2(WINDOW)
) (
	input  wire logic                       clk,
	input  wire lane_ctrl_t                 ctrl,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic [AW-1:0]              wr_addr,
	input  wire logic [AW-1:0]              rd_addr,
	input  wire logic [PEAK_W-1:0]          floor_val,
	output lane_res_t                       res
);

	logic signed [SAMPLE_W-1:0] mem [WINDOW];
	logic signed [SAMPLE_W-1:0] rdata_s1;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic signed [SAMPLE_W-1:0] cand;
	logic [PEAK_W-1:0]          lim;
	logic [PEAK_W-1:0]          peak;
	logic [PEAK_W-1:0]          peak_q;
	logic                       neg_q;
	logic [SAMPLE_W-1:0]        mag;
	logic [DIVIDEND_W-1:0]      quo;
	logic [NORM_W-1:0]          neg_quo;

	// Window memory: the new sample is written on request, the scan reads one entry a cycle.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mem[wr_addr] <= sample;
		end
		if (ctrl.scan_rd) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Entries never written since reset count as zero.
	assign cand = ctrl.acc_ok ? rdata_s1 : '0;

	// Running signed maximum over the scan.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sample_q <= sample;
			max_q    <= SAMPLE_MIN;
		end else if (ctrl.acc && (cand > max_q)) begin
			max_q <= cand;
		end
	end

	// Raise the maximum to the floor; a zero floor acts as one.
	always_comb begin
		lim  = (floor_val == '0) ? PEAK_W'(1) : floor_val;
		peak = (max_q < $signed({1'b0, lim})) ? lim : max_q[PEAK_W-1:0];
		mag  = sample_q[SAMPLE_W-1] ? (~sample_q + 1'b1) : sample_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.div_start) begin
			peak_q <= peak;
			neg_q  <= sample_q[SAMPLE_W-1];
		end
	end

	spwn_div u_div (
		.clk      (clk),
		.start    (ctrl.div_start),
		.step     (ctrl.div_step),
		.dividend ({mag, {FRAC_SHIFT{1'b0}}}),
		.divisor  (peak),
		.quotient (quo)
	);

	// Restore the sign and clamp to the Q7.12 range.
	always_comb begin
		neg_quo  = ~quo[NORM_W-1:0] + 1'b1;
		res.peak = peak_q;
		if (neg_q) begin
			res.norm = (quo > NEG_LIM) ? NORM_MIN : $signed(neg_quo);
		end else begin
			res.norm = (quo > POS_LIM) ? NORM_MAX : $signed(quo[NORM_W-1:0]);
		end
	end

endmodule

`default_nettype wire

>>> rtl/spwn_merge.sv
`default_nettype none

module spwn_merge import spwn_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire lane_res_t left_res,
	input  wire lane_res_t right_res,
	input  wire logic      out_stall,
	output logic           out_valid,
	output out_item_t      out_data,
	output logic           free
);

	logic                     valid_q;
	out_item_t                data_q;
	logic signed [NORM_W:0]   sum;

	// Mono is the floor of half the sum of both quotients.
	assign sum  = {left_res.norm[NORM_W-1], left_res.norm}
		+ {right_res.norm[NORM_W-1], right_res.norm};
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q.left_norm  <= left_res.norm;
			data_q.right_norm <= right_res.norm;
			data_q.mono_norm  <= sum[NORM_W:1];
			data_q.left_peak  <= left_res.peak;
			data_q.right_peak <= right_res.peak;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

>>> rtl/stereo_peak_window_normalizer.sv
// Sequence: after an accepted request each lane scans its window one entry a cycle, then a
// drain step, a divider load and a 28-step bit-serial divide; the result waits in the final
// state until the output register is free. No new request is accepted until then.
// Reset: asynchronous, active low; the windows read as zero until written, tracked by a fill
// count, so no clearing pass is needed. The floor register resets to 3277.
`default_nettype none

module stereo_peak_window_normalizer import spwn_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire in_item_t          in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_item_t              out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [PEAK_W-1:0] cfg_data
);

	localparam int AW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW);
	localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(DIV_STEPS - 1);

	state_t            state_q;
	state_t            state_nx;
	lane_ctrl_t        ctrl;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     scan_q;
	logic [CW-1:0]     fill_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              acc_s1;
	logic              ok_s1;
	logic [PEAK_W-1:0] floor_q;
	logic              merge_free;
	logic              merge_load;
	lane_res_t         left_res;
	lane_res_t         right_res;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_RESET;
		end else if (cfg_valid) begin
			floor_q <= cfg_data;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nx = ST_SCAN;
			ST_SCAN:  if (scan_q == LAST_ADDR) state_nx = ST_DRAIN;
			ST_DRAIN: state_nx = ST_DIVLD;
			ST_DIVLD: state_nx = ST_DIV;
			ST_DIV:   if (dcnt_q == LAST_STEP) state_nx = ST_DONE;
			ST_DONE:  if (merge_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		ctrl.load      = (state_q == ST_IDLE) && in_valid;
		ctrl.scan_rd   = (state_q == ST_SCAN);
		ctrl.acc       = acc_s1;
		ctrl.acc_ok    = ok_s1;
		ctrl.div_start = (state_q == ST_DIVLD);
		ctrl.div_step  = (state_q == ST_DIV);
		merge_load     = (state_q == ST_DONE) && merge_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Ring head, fill count, scan address, divide step counter and the delayed scan flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			scan_q <= '0;
			dcnt_q <= '0;
			acc_s1 <= 1'b0;
			ok_s1  <= 1'b0;
		end else begin
			if (ctrl.load) begin
				head_q <= (head_q == LAST_ADDR) ? '0 : head_q + 1'b1;
				if (fill_q != FULL_CNT) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (ctrl.scan_rd) begin
				scan_q <= (scan_q == LAST_ADDR) ? '0 : scan_q + 1'b1;
			end
			if (ctrl.div_start) begin
				dcnt_q <= '0;
			end else if (ctrl.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			acc_s1 <= ctrl.scan_rd;
			ok_s1  <= CW'(scan_q) < fill_q;
		end
	end

	spwn_lane #(.WINDOW(WINDOW)) u_left (
		.clk       (clk),
		.ctrl      (ctrl),
		.sample    (in_data.left_sample),
		.wr_addr   (head_q),
		.rd_addr   (scan_q),
		.floor_val (floor_q),
		.res       (left_res)
	);

	spwn_lane #(.WINDOW(WINDOW)) u_right (
		.clk       (clk),
		.ctrl      (ctrl),
		.sample    (in_data.right_sample),
		.wr_addr   (head_q),
		.rd_addr   (scan_q),
		.floor_val (floor_q),
		.res       (right_res)
	);

	spwn_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (merge_load),
		.left_res  (left_res),
		.right_res (right_res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.free      (merge_free)
	);

endmodule

`default_nettype wire
